// ----- rtl/core/hbc_pkg.sv -----
// Shared types and constants for the Hill cipher block stream.
// Used by every module under rtl/core; no dependencies of its own.
package hbc_pkg;

  // Largest block length and matrix order supported
  localparam int unsigned MAX_ORDER = 3;
  localparam int unsigned ENTRY_W   = 5;
  localparam int unsigned KEY_W     = 45;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned ORDER_W   = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VAL_W     = 9;
  localparam int unsigned PROD_W    = 15;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned POS_W     = 15;
  localparam int unsigned RECIP_W   = 16;
  localparam int unsigned QUOT_W    = 11;
  localparam int unsigned LETTER_W  = 7;

  localparam logic [BYTE_W-1:0]   LETTER_A    = 8'd65;
  localparam logic [POS_W-1:0]    MODULUS     = 15'd26;
  // 26 * 233: lifts the most negative row sum (3 * 31 * -65) above zero
  localparam logic [SUM_W-1:0]    SUM_OFFSET  = 16'd6058;
  // ceil(2^20 / 26); exact floor quotient for every lifted sum
  localparam logic [RECIP_W-1:0]  RECIP       = 16'd40330;
  localparam int unsigned         RECIP_SHIFT = 20;

  // Register map, indexed by paddr[4:3]
  typedef enum logic [1:0] {
    REG_MATRIX_SIZE = 2'd0,
    REG_KEY_MATRIX  = 2'd1,
    REG_INV_MATRIX  = 2'd2,
    REG_DECRYPT     = 2'd3
  } reg_idx_e;

  // Settings seen by the datapath
  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [KEY_W-1:0]   matrix;
  } cfg_t;

  // One closed block, handed from the front to the back
  typedef struct packed {
    logic                             msg_end;
    logic [MAX_ORDER-1:0][VAL_W-1:0]  vals;
  } job_t;

endpackage

// ----- rtl/core/hill_block_cipher_stream.sv -----
// Top level of the Hill cipher (mod 26) block stream.
// Ties hbc_regs, hbc_front, hbc_queue and hbc_back together; uses hbc_pkg.
//
//  Channel   Dir   Handshake                 Payload
//  s_axis    in    tvalid/tready             tdata[7:0] byte, tlast message end
//  m_axis    out   tvalid/tready             tdata[6:0] letter, tlast block end,
//                                            tuser message end
//  apb       in    psel/penable, pready = 1  64-bit registers at 8*index
//
// One request in and one letter out per cycle while the queue is not full and
// the output is not stalled; a closing byte passes the queue, then products,
// row sum, mod 26 quotient and output register before its first letter.
// Reset is asynchronous and empties the block and queue; no clearing pass.
// Output stalls freeze the back pipeline; the queue lets the front keep
// taking bytes until it holds QUEUE_DEPTH closed blocks.
module hill_block_cipher_stream #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] letter_byte
  input  logic        s_axis_tlast,   // message_end
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_letter, [7] zero
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // [0] out_message_end
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import hbc_pkg::*;

  cfg_t                cfg;
  job_t                push_job;
  job_t                head_job;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;
  logic [LETTER_W-1:0] letter;

  hbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .order_i      (cfg.order),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .queue_full_i (q_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .job_o        (push_job)
  );

  hbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  hbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .job_valid_i  (q_valid),
    .job_i        (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (letter),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, letter};

endmodule

// ----- rtl/core/hbc_regs.sv -----
// Configuration registers and APB-style access port.
// Depends on hbc_pkg for the register map and cfg_t.
module hbc_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hbc_pkg::CFG_AW-1:0] paddr,
  input  logic [hbc_pkg::CFG_DW-1:0] pwdata,
  output logic [hbc_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output hbc_pkg::cfg_t             cfg_o
);
  import hbc_pkg::*;

  logic [ORDER_W-1:0] size_q;
  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   inv_q;
  logic               mode_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 2'd2;
      key_q  <= '0;
      inv_q  <= '0;
      mode_q <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_MATRIX_SIZE: size_q <= pwdata[ORDER_W-1:0];
        REG_KEY_MATRIX:  key_q  <= pwdata[KEY_W-1:0];
        REG_INV_MATRIX:  inv_q  <= pwdata[KEY_W-1:0];
        REG_DECRYPT:     mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_MATRIX_SIZE: prdata = {{(CFG_DW-ORDER_W){1'b0}}, size_q};
      REG_KEY_MATRIX:  prdata = {{(CFG_DW-KEY_W){1'b0}}, key_q};
      REG_INV_MATRIX:  prdata = {{(CFG_DW-KEY_W){1'b0}}, inv_q};
      REG_DECRYPT:     prdata = {{(CFG_DW-1){1'b0}}, mode_q};
      default:         prdata = '0;
    endcase
  end

  // Order in use: zero acts as one, too large acts as the maximum
  always_comb begin
    if (size_q == '0) begin
      cfg_o.order = ORDER_W'(1);
    end else if (32'(size_q) > MAX_ORDER) begin
      cfg_o.order = ORDER_W'(MAX_ORDER);
    end else begin
      cfg_o.order = size_q;
    end
    cfg_o.matrix = mode_q ? inv_q : key_q;
  end

endmodule

// ----- rtl/core/hbc_front.sv -----
// Front end: gathers message bytes into a block and closes it when full
// or at message end. Depends on hbc_pkg for job_t.
module hbc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hbc_pkg::ORDER_W-1:0] order_i,
  input  logic                        in_valid_i,
  input  logic [hbc_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                        in_end_i,
  input  logic                        queue_full_i,
  output logic                        in_ready_o,
  output logic                        push_o,
  output hbc_pkg::job_t               job_o
);
  import hbc_pkg::*;

  logic [BYTE_W-1:0]  store_q [MAX_ORDER];
  logic [ORDER_W-1:0] fill_q;
  logic [ORDER_W-1:0] fill_d;
  logic [ORDER_W-1:0] idx;
  logic               accept;
  logic               close;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // Slot for this byte; held bytes are dropped if the order shrank
  assign idx   = (fill_q >= order_i) ? '0 : fill_q;
  assign close = ((idx + ORDER_W'(1)) >= order_i) | in_end_i;
  assign push_o = accept & close;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = close ? '0 : idx + ORDER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Byte store, written at the current slot
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (accept && idx == ORDER_W'(c)) begin
        store_q[c] <= in_byte_i;
      end
    end
  end

  // Block values: byte - 'A', padded with zero past the last byte
  always_comb begin
    job_o.msg_end = in_end_i;
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (ORDER_W'(c) < idx) begin
        job_o.vals[c] = {1'b0, store_q[c]} - {1'b0, LETTER_A};
      end else if (ORDER_W'(c) == idx) begin
        job_o.vals[c] = {1'b0, in_byte_i} - {1'b0, LETTER_A};
      end else begin
        job_o.vals[c] = '0;
      end
    end
  end

endmodule

// ----- rtl/core/hbc_queue.sv -----
// Short job queue between front and back ends, held in flip-flops.
// Depends on hbc_pkg for job_t.
module hbc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hbc_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output hbc_pkg::job_t head_o
);
  import hbc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

endmodule

// ----- rtl/core/hbc_back.sv -----
// Back end: one result letter per cycle, row sum then mod 26 over a
// stalling pipeline with an output register. Depends on hbc_pkg.
module hbc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hbc_pkg::cfg_t                 cfg_i,
  input  logic                          job_valid_i,
  input  hbc_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hbc_pkg::LETTER_W-1:0]  out_letter_o,
  output logic                          out_last_o,
  output logic                          out_end_o
);
  import hbc_pkg::*;

  logic                     adv;
  logic                     issue;
  logic                     last_row;
  logic [ORDER_W-1:0]       row_q;
  logic [ENTRY_W-1:0]       ent [MAX_ORDER];

  logic                     s1_v_q, s1_last_q, s1_end_q;
  logic signed [PROD_W-1:0] s1_prod_q [MAX_ORDER];
  logic                     s2_v_q, s2_last_q, s2_end_q;
  logic [POS_W-1:0]         s2_x_q;
  logic                     s3_v_q, s3_last_q, s3_end_q;
  logic [POS_W-1:0]         s3_x_q;
  logic [QUOT_W-1:0]        s3_quot_q;
  logic                     o_v_q, o_last_q, o_end_q;
  logic [LETTER_W-1:0]      o_letter_q;

  logic signed [SUM_W-1:0]  row_sum;
  logic [SUM_W-1:0]         lifted;
  logic [POS_W+RECIP_W-1:0] quot_full;
  logic [POS_W-1:0]         rem;

  // Whole pipeline moves when the output register is free or taken
  assign adv      = ~o_v_q | out_ready_i;
  assign issue    = adv & job_valid_i;
  assign last_row = (row_q == cfg_i.order - ORDER_W'(1));
  assign pop_o    = issue & last_row;

  // Key entries of the current row
  always_comb begin
    for (int c = 0; c < MAX_ORDER; c++) begin
      ent[c] = cfg_i.matrix[ENTRY_W*(MAX_ORDER*32'(row_q) + c) +: ENTRY_W];
    end
  end

  // Row sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (issue) begin
      row_q <= last_row ? '0 : row_q + ORDER_W'(1);
    end
  end

  // Sum of products, lifted above zero
  always_comb begin
    row_sum = '0;
    for (int c = 0; c < MAX_ORDER; c++) begin
      row_sum = row_sum + SUM_W'(s1_prod_q[c]);
    end
    lifted    = row_sum + SUM_OFFSET;
    quot_full = s2_x_q * RECIP;
    rem       = s3_x_q - POS_W'(s3_quot_q * MODULUS);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      o_v_q  <= s3_v_q;
    end
  end

  // Datapath stages: products, lifted sum, quotient, letter
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < MAX_ORDER; c++) begin
        s1_prod_q[c] <= PROD_W'($signed({1'b0, ent[c]}) * $signed(job_i.vals[c]));
      end
      s1_last_q  <= last_row;
      s1_end_q   <= last_row & job_i.msg_end;
      s2_x_q     <= lifted[POS_W-1:0];
      s2_last_q  <= s1_last_q;
      s2_end_q   <= s1_end_q;
      s3_x_q     <= s2_x_q;
      s3_quot_q  <= quot_full[RECIP_SHIFT +: QUOT_W];
      s3_last_q  <= s2_last_q;
      s3_end_q   <= s2_end_q;
      o_letter_q <= LETTER_W'(rem) + LETTER_A[LETTER_W-1:0];
      o_last_q   <= s3_last_q;
      o_end_q    <= s3_end_q;
    end
  end

  assign out_valid_o  = o_v_q;
  assign out_letter_o = o_letter_q;
  assign out_last_o   = o_last_q;
  assign out_end_o    = o_end_q;

endmodule
